>>> design/rmt_pkg.sv
// Shared constants, field layout and types for the rectangle merge table.
`timescale 1ns / 1ps
package rmt_pkg;

  // Parameter defaults
  localparam int LAYER_COUNT_DEF = 16;
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int COORD_BITS_DEF  = 16;

  // Fixed field widths on the ports
  localparam int LAYER_W  = 4;
  localparam int SIG_W    = 16;
  localparam int FIELD_W  = 16;
  localparam int EIDX_W   = 10;
  localparam int RIDX_W   = 10;
  localparam int LCOUNT_W = 11;
  localparam int STATUS_W = 3;

  // Input word layout
  localparam int IN_TDATA_W  = 96;
  localparam int IN_TUSER_W  = 1;
  localparam int IN_LAYER_LSB = 0;
  localparam int IN_SIG_LSB   = 4;
  localparam int IN_MINX_LSB  = 20;
  localparam int IN_MINY_LSB  = 36;
  localparam int IN_MAXX_LSB  = 52;
  localparam int IN_MAXY_LSB  = 68;
  localparam int IN_EIDX_LSB  = 84;

  // Output word layout
  localparam int OUT_TDATA_W  = 104;
  localparam int OUT_TUSER_W  = 3;
  localparam int OUT_PAD_W    = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_MERGED   = 3'd0,
    ST_APPENDED = 3'd1,
    ST_FULL     = 3'd2,
    ST_READ     = 3'd3,
    ST_BEYOND   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ_ISSUE,
    S_READ_DATA,
    S_RESP
  } state_e;

endpackage

>>> design/rmt_store.sv
// Single-port-write, single-port-read table memory with registered read data.
`timescale 1ns / 1ps
module rmt_store #(
  parameter int DEPTH = rmt_pkg::LAYER_COUNT_DEF * rmt_pkg::TABLE_DEPTH_DEF,
  parameter int WIDTH = rmt_pkg::SIG_W + 4 * rmt_pkg::COORD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> design/rmt_match.sv
// Compare unit: tests one stored entry against the new rectangle and forms the extension.
`timescale 1ns / 1ps
module rmt_match #(
  parameter int COORD_BITS = rmt_pkg::COORD_BITS_DEF
) (
  input  logic [rmt_pkg::SIG_W-1:0] entry_sig_i,
  input  logic [4*COORD_BITS-1:0]   entry_rect_i,
  input  logic [rmt_pkg::SIG_W-1:0] item_sig_i,
  input  logic [4*COORD_BITS-1:0]   item_rect_i,
  output logic                      hit_o,
  output logic [4*COORD_BITS-1:0]   rect_o
);

  import rmt_pkg::*;

  logic [COORD_BITS-1:0] x0, y0, x1, y1;
  logic [COORD_BITS-1:0] nx0, ny0, nx1, ny1;
  logic                  x_eq, y_eq;

  assign x0  = entry_rect_i[0*COORD_BITS +: COORD_BITS];
  assign y0  = entry_rect_i[1*COORD_BITS +: COORD_BITS];
  assign x1  = entry_rect_i[2*COORD_BITS +: COORD_BITS];
  assign y1  = entry_rect_i[3*COORD_BITS +: COORD_BITS];
  assign nx0 = item_rect_i[0*COORD_BITS +: COORD_BITS];
  assign ny0 = item_rect_i[1*COORD_BITS +: COORD_BITS];
  assign nx1 = item_rect_i[2*COORD_BITS +: COORD_BITS];
  assign ny1 = item_rect_i[3*COORD_BITS +: COORD_BITS];

  assign x_eq = (x0 == nx0) && (x1 == nx1);
  assign y_eq = (y0 == ny0) && (y1 == ny1);

  // Priority: grow up, grow down, grow right, grow left
  always_comb begin
    hit_o  = 1'b0;
    rect_o = entry_rect_i;
    if (entry_sig_i == item_sig_i) begin
      if (x_eq && (ny0 == y1)) begin
        hit_o  = 1'b1;
        rect_o = {ny1, x1, y0, x0};
      end else if (x_eq && (ny1 == y0)) begin
        hit_o  = 1'b1;
        rect_o = {y1, x1, ny0, x0};
      end else if (y_eq && (nx0 == x1)) begin
        hit_o  = 1'b1;
        rect_o = {y1, nx1, y0, x0};
      end else if (y_eq && (nx1 == x0)) begin
        hit_o  = 1'b1;
        rect_o = {y1, x1, y0, nx0};
      end
    end
  end

endmodule

>>> design/rectangle_merge_table.sv
// Top level of the rectangle merge table: sequencer, entry counts and output stage.
`timescale 1ns / 1ps
// Usage
//   Input stream (s_axis_*): one word per command. tuser[0] is the action:
//   0 adds a rectangle to the layer's table, 1 reads entry entry_index.
//   Output stream (m_axis_*): exactly one result word per command; tuser is
//   the status (merged, appended, table full, read done, read beyond count).
// Sequencing
//   An add scans the layer's table one entry per cycle through the single
//   read port of the table memory. The scan stops at the first entry that
//   can be extended; otherwise it runs to the layer's entry count and
//   appends, or reports the table full when it holds TABLE_DEPTH entries.
//   A read issues its address, then takes the registered read data; a read
//   past the count or to a bad layer goes straight to the result.
//   One command is in work at a time; s_axis_tready_o is high while idle, and
//   the next command can be accepted in the cycle after a result is loaded.
// Reset
//   Clears all entry counts, so every table is empty; table contents are
//   not cleared and need no clearing pass.
// Stall
//   The result sits in an output register; the next command is accepted
//   while it waits, and that command's result is held until the register frees.
module rectangle_merge_table #(
  parameter int LAYER_COUNT = rmt_pkg::LAYER_COUNT_DEF,
  parameter int TABLE_DEPTH = rmt_pkg::TABLE_DEPTH_DEF,
  parameter int COORD_BITS  = rmt_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // layer, signal_id, min_x, min_y, max_x, max_y, entry_index, zero pad
  input  logic [rmt_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // action
  input  logic [rmt_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // result_index, entry_signal, entry_min_x, entry_min_y, entry_max_x,
  // entry_max_y, layer_count, zero pad
  output logic [rmt_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // status
  output logic [rmt_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o
);

  import rmt_pkg::*;

  localparam int LAY_W  = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > EIDX_W) ? CNT_W : EIDX_W;
  localparam int DEPTH  = LAYER_COUNT * TABLE_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RECT_W = 4 * COORD_BITS;
  localparam int WORD_W = SIG_W + RECT_W;

  // Input word fields
  logic                  in_action;
  logic [LAYER_W-1:0]    in_layer;
  logic [SIG_W-1:0]      in_sig;
  logic [RECT_W-1:0]     in_rect;
  logic [EIDX_W-1:0]     in_eidx;
  logic                  in_ok;
  logic [LAY_W-1:0]      in_lay;
  logic [CNT_W-1:0]      in_cnt;
  logic                  in_eidx_lt;

  // Sequencer and item registers
  state_e                state_q, state_d;
  logic [LAY_W-1:0]      lay_q;
  logic [SIG_W-1:0]      sig_q;
  logic [RECT_W-1:0]     nrect_q;
  logic [EIDX_W-1:0]     eidx_q;
  logic [CNT_W-1:0]      cur_cnt_q;
  logic [ADDR_W-1:0]     base_q;
  logic [CNT_W-1:0]      rd_idx_q;
  logic                  pend_q;
  logic [IDX_W-1:0]      pend_idx_q;
  logic [CNT_W-1:0]      cnt_q [LAYER_COUNT];

  // Result and output stage
  status_e               res_status_q;
  logic [RIDX_W-1:0]     res_index_q;
  logic [SIG_W-1:0]      res_sig_q;
  logic [RECT_W-1:0]     res_rect_q;
  logic [CNT_W-1:0]      res_count_q;
  logic                  m_valid_q;
  status_e               out_status_q;
  logic [OUT_TDATA_W-1:0] out_tdata_q;

  // Control
  logic                  accept;
  logic                  issue;
  logic                  scan_hit;
  logic                  scan_done;
  logic                  tbl_full;
  logic                  do_append;
  logic                  out_load;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [WORD_W-1:0]     wr_data;
  logic [WORD_W-1:0]     rd_data;
  logic                  mt_hit;
  logic [RECT_W-1:0]     mt_rect;

  assign in_action = s_axis_tuser_i[0];
  assign in_layer  = s_axis_tdata_i[IN_LAYER_LSB +: LAYER_W];
  assign in_sig    = s_axis_tdata_i[IN_SIG_LSB +: SIG_W];
  assign in_eidx   = s_axis_tdata_i[IN_EIDX_LSB +: EIDX_W];
  assign in_rect   = {COORD_BITS'(s_axis_tdata_i[IN_MAXY_LSB +: FIELD_W]),
                      COORD_BITS'(s_axis_tdata_i[IN_MAXX_LSB +: FIELD_W]),
                      COORD_BITS'(s_axis_tdata_i[IN_MINY_LSB +: FIELD_W]),
                      COORD_BITS'(s_axis_tdata_i[IN_MINX_LSB +: FIELD_W])};

  assign in_ok      = (32'(in_layer) < 32'(LAYER_COUNT));
  assign in_lay     = LAY_W'(in_layer);
  assign in_cnt     = in_ok ? cnt_q[in_lay] : '0;
  assign in_eidx_lt = (CMP_W'(in_eidx) < CMP_W'(in_cnt));

  rmt_store #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_W)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  rmt_match #(
    .COORD_BITS (COORD_BITS)
  ) u_match (
    .entry_sig_i  (rd_data[RECT_W +: SIG_W]),
    .entry_rect_i (rd_data[RECT_W-1:0]),
    .item_sig_i   (sig_q),
    .item_rect_i  (nrect_q),
    .hit_o        (mt_hit),
    .rect_o       (mt_rect)
  );

  // Control outputs of the sequencer
  always_comb begin
    accept    = s_axis_tvalid_i && (state_q == S_IDLE);
    issue     = (state_q == S_SCAN) && (rd_idx_q < cur_cnt_q);
    scan_hit  = (state_q == S_SCAN) && pend_q && mt_hit;
    scan_done = (state_q == S_SCAN) && !pend_q && !issue;
    tbl_full  = (cur_cnt_q >= CNT_W'(TABLE_DEPTH));
    do_append = scan_done && !tbl_full;
    out_load  = (state_q == S_RESP) && (!m_valid_q || m_axis_tready_i);
    rd_en     = issue || (state_q == S_READ_ISSUE);
    if (state_q == S_READ_ISSUE) begin
      rd_addr = base_q + ADDR_W'(eidx_q);
    end else begin
      rd_addr = base_q + ADDR_W'(rd_idx_q);
    end
    wr_en = scan_hit || do_append;
    if (scan_hit) begin
      wr_addr = base_q + ADDR_W'(pend_idx_q);
      wr_data = {sig_q, mt_rect};
    end else begin
      wr_addr = base_q + ADDR_W'(cur_cnt_q);
      wr_data = {sig_q, nrect_q};
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!in_ok || (in_action && !in_eidx_lt)) begin
            state_d = S_RESP;
          end else if (in_action) begin
            state_d = S_READ_ISSUE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit || scan_done) begin
          state_d = S_RESP;
        end
      end
      S_READ_ISSUE: state_d = S_READ_DATA;
      S_READ_DATA:  state_d = S_RESP;
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
      for (int l = 0; l < LAYER_COUNT; l++) begin
        cnt_q[l] <= '0;
      end
    end else begin
      state_q <= state_d;
      pend_q  <= issue;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (do_append) begin
        cnt_q[lay_q] <= cur_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lay_q     <= in_lay;
      sig_q     <= in_sig;
      nrect_q   <= in_rect;
      eidx_q    <= in_eidx;
      cur_cnt_q <= in_cnt;
      base_q    <= ADDR_W'(32'(in_lay) * TABLE_DEPTH);
      rd_idx_q  <= '0;
      // Preload the answer for a refused command; later states overwrite it
      res_status_q <= in_action ? ST_BEYOND : ST_FULL;
      res_index_q  <= in_action ? RIDX_W'(in_eidx) : '0;
      res_sig_q    <= '0;
      res_rect_q   <= '0;
      res_count_q  <= in_cnt;
    end
    if (issue) begin
      rd_idx_q   <= rd_idx_q + 1'b1;
      pend_idx_q <= rd_idx_q[IDX_W-1:0];
    end
    if (scan_hit) begin
      res_status_q <= ST_MERGED;
      res_index_q  <= RIDX_W'(pend_idx_q);
      res_sig_q    <= sig_q;
      res_rect_q   <= mt_rect;
    end
    if (do_append) begin
      res_status_q <= ST_APPENDED;
      res_index_q  <= RIDX_W'(cur_cnt_q);
      res_sig_q    <= sig_q;
      res_rect_q   <= nrect_q;
      res_count_q  <= cur_cnt_q + 1'b1;
    end
    if (state_q == S_READ_DATA) begin
      res_status_q <= ST_READ;
      res_sig_q    <= rd_data[RECT_W +: SIG_W];
      res_rect_q   <= rd_data[RECT_W-1:0];
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_tdata_q  <= {{OUT_PAD_W{1'b0}},
                       LCOUNT_W'(res_count_q),
                       FIELD_W'(res_rect_q[3*COORD_BITS +: COORD_BITS]),
                       FIELD_W'(res_rect_q[2*COORD_BITS +: COORD_BITS]),
                       FIELD_W'(res_rect_q[1*COORD_BITS +: COORD_BITS]),
                       FIELD_W'(res_rect_q[0*COORD_BITS +: COORD_BITS]),
                       res_sig_q,
                       res_index_q};
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_tdata_q;
  assign m_axis_tuser_o  = out_status_q;

endmodule
